// File: hdl/lge_pkg.sv
//------------------------------------------------------------------------------
// lge_pkg
// Shared types, constants and helpers for the life generation engine.
//------------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CMD_W     = 2;

  localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_RST = CFG_W'(MAX_COLS);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_FETCH,
    ST_SHIFT,
    ST_LOAD,
    ST_CALC,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cu_ctrl_t;

  // bit i set when column i is inside the columns in use
  function automatic row_t col_mask(logic [CFG_W-1:0] n);
    row_t m;
    for (int i = 0; i < MAX_COLS; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lge_if.sv
//------------------------------------------------------------------------------
// lge_if
// Valid/ready channel interfaces: commands, results and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface lge_in_if import lge_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ROW_W-1:0]    row_index;
  logic [COL_W-1:0]    col_index;
  logic                cell_value;

  modport source (output valid, command, row_index, col_index, cell_value, input ready);
  modport sink   (input valid, command, row_index, col_index, cell_value, output ready);
endinterface

interface lge_out_if import lge_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cell_alive;
  logic [CMD_W-1:0]    done_kind;
  logic                range_error;

  modport source (output valid, cell_alive, done_kind, range_error, input ready);
  modport sink   (input valid, cell_alive, done_kind, range_error, output ready);
endinterface

interface lge_cfg_if import lge_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/lge_ram.sv
//------------------------------------------------------------------------------
// lge_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/lge_cell_unit.sv
//------------------------------------------------------------------------------
// lge_cell_unit
// Shared B3/S23 rule unit: walks a three-row window one column per cycle
// while shift is set, and shifts each new cell into the result row.
//------------------------------------------------------------------------------
`default_nettype none

module lge_cell_unit import lge_pkg::*; (
  input  wire logic     clk,
  input  wire cu_ctrl_t ctrl,
  input  wire row_t     row_a,
  input  wire row_t     row_b,
  input  wire row_t     row_c,
  output row_t          next_row
);

  logic [MAX_COLS+1:0] wa_r, wb_r, wc_r;
  row_t                acc_r;
  logic [3:0]          live;
  logic                born;

  always_comb begin
    live = 4'(wa_r[0]) + 4'(wa_r[1]) + 4'(wa_r[2])
         + 4'(wb_r[0])               + 4'(wb_r[2])
         + 4'(wc_r[0]) + 4'(wc_r[1]) + 4'(wc_r[2]);
    born = (live == 4'd3) || ((live == 4'd2) && wb_r[1]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wa_r <= {1'b0, row_a, 1'b0};
      wb_r <= {1'b0, row_b, 1'b0};
      wc_r <= {1'b0, row_c, 1'b0};
    end else if (ctrl.shift) begin
      wa_r  <= {1'b0, wa_r[MAX_COLS+1:1]};
      wb_r  <= {1'b0, wb_r[MAX_COLS+1:1]};
      wc_r  <= {1'b0, wc_r[MAX_COLS+1:1]};
      acc_r <= {born, acc_r[MAX_COLS-1:1]};
    end
  end

  assign next_row = acc_r;

endmodule

`default_nettype wire

// File: hdl/life_generation_engine.sv
//------------------------------------------------------------------------------
// life_generation_engine
// Bounded-grid Game of Life (B3/S23): cell write, cell read and generation
// step over a row-wide cell RAM, one cell evaluated per cycle.
//
//  channel  | dir | signals                                        | accept
//  ---------+-----+------------------------------------------------+-------------
//  in_chan  | in  | command, row_index, col_index, cell_value      | valid & ready
//  out_chan | out | cell_alive, done_kind, range_error             | valid & ready
//  cfg_chan | in  | index (0 rows_in_use, 1 cols_in_use), data     | valid & ready
//
//  Write: row read, modify/write, result. Read: row read, cell select, result.
//  Step: each row takes a fetch, a window shift, a window load, a full-width
//  pass through the cell rule unit and a row write-back.
//  Reset clears all cells through per-row valid bits; no clearing pass.
//  in_chan is ready only when the sequencer is idle; a result waits in the
//  output register while out_chan stalls, and the next result holds the sequencer.
//------------------------------------------------------------------------------
`default_nettype none

module life_generation_engine import lge_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lge_in_if.sink     in_chan,
  lge_out_if.source  out_chan,
  lge_cfg_if.sink    cfg_chan
);

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  rows_r, rows_nxt, cols_r, cols_nxt;
  logic [CFG_W-1:0]  rows_eff, cols_eff;
  logic [MAX_ROWS-1:0] valid_r, valid_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ROW_W-1:0]  rd_row_r, rd_row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              val_r, val_nxt;
  logic [CFG_W-1:0]  f_r, f_nxt;
  logic [ROW_W-1:0]  wr_row_r, wr_row_nxt;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  row_t              row_a_r, row_a_nxt, row_b_r, row_b_nxt, row_c_r, row_c_nxt;
  logic              res_alive_r, res_alive_nxt, res_err_r, res_err_nxt;
  logic [CMD_W-1:0]  res_kind_r, res_kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_alive_r, out_alive_nxt, out_err_r, out_err_nxt;
  logic [CMD_W-1:0]  out_kind_r, out_kind_nxt;

  logic              in_accept, in_range, slot_free;
  row_t              cmask, rd_data, rd_eff, cu_row, cell_wdata;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  row_t              ram_wdata;
  cu_ctrl_t          cu_ctrl;

  assign rows_eff  = (rows_r > ROWS_RST) ? ROWS_RST : rows_r;
  assign cols_eff  = (cols_r > COLS_RST) ? COLS_RST : cols_r;
  assign cmask     = col_mask(cols_eff);
  assign rd_eff    = valid_r[rd_row_r] ? rd_data : '0;
  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_range  = (CFG_W'(in_chan.row_index) < rows_eff) &&
                     (CFG_W'(in_chan.col_index) < cols_eff);
  assign slot_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_alive = out_alive_r;
  assign out_chan.done_kind  = out_kind_r;
  assign out_chan.range_error = out_err_r;

  lge_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  lge_cell_unit u_cell_unit (
    .clk      (clk),
    .ctrl     (cu_ctrl),
    .row_a    (row_a_r & cmask),
    .row_b    (row_b_r & cmask),
    .row_c    (row_c_r & cmask),
    .next_row (cu_row)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (cmd_t'(in_chan.command))
            CMD_WRITE, CMD_READ: state_nxt = in_range ? ST_ACC_RD : ST_RESP;
            CMD_STEP: state_nxt = ((rows_eff == '0) || (cols_eff == '0)) ?
                                  ST_RESP : ST_FETCH;
            CMD_NONE: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ACC_RD: state_nxt = ST_RESP;
      ST_FETCH:  state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = (f_r == '0) ? ST_FETCH : ST_LOAD;
      ST_LOAD:   state_nxt = ST_CALC;
      ST_CALC:   state_nxt = (col_cnt_r == '1) ? ST_WRITE : ST_CALC;
      ST_WRITE:  state_nxt = ((CFG_W'(wr_row_r) + CFG_W'(1)) == rows_eff) ?
                             ST_RESP : ST_FETCH;
      ST_RESP:   state_nxt = slot_free ? ST_IDLE : ST_RESP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    valid_nxt     = valid_r;
    cmd_nxt       = cmd_r;
    rd_row_nxt    = rd_row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    f_nxt         = f_r;
    wr_row_nxt    = wr_row_r;
    col_cnt_nxt   = col_cnt_r;
    row_a_nxt     = row_a_r;
    row_b_nxt     = row_b_r;
    row_c_nxt     = row_c_r;
    res_alive_nxt = res_alive_r;
    res_kind_nxt  = res_kind_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_alive_nxt = out_alive_r;
    out_kind_nxt  = out_kind_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_row_r;
    ram_wdata     = '0;
    ram_raddr     = rd_row_r;
    cu_ctrl       = '0;
    cell_wdata    = rd_eff;
    cell_wdata[col_r] = val_r;

    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_ROWS: rows_nxt = cfg_chan.data;
        REG_COLS: cols_nxt = cfg_chan.data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt       = cmd_t'(in_chan.command);
          rd_row_nxt    = in_chan.row_index;
          ram_raddr     = in_chan.row_index;
          col_nxt       = in_chan.col_index;
          val_nxt       = in_chan.cell_value;
          res_alive_nxt = 1'b0;
          res_kind_nxt  = in_chan.command;
          res_err_nxt   = ((cmd_t'(in_chan.command) == CMD_WRITE) ||
                           (cmd_t'(in_chan.command) == CMD_READ)) && !in_range;
          f_nxt         = '0;
          row_b_nxt     = '0;
          row_c_nxt     = '0;
        end
      end
      ST_ACC_RD: begin
        if (cmd_r == CMD_READ) begin
          res_alive_nxt = rd_eff[col_r];
        end else begin
          ram_we              = 1'b1;
          ram_waddr           = rd_row_r;
          ram_wdata           = cell_wdata;
          valid_nxt[rd_row_r] = 1'b1;
        end
      end
      ST_FETCH: begin
        ram_raddr  = f_r[ROW_W-1:0];
        rd_row_nxt = f_r[ROW_W-1:0];
      end
      ST_SHIFT: begin
        row_a_nxt  = row_b_r;
        row_b_nxt  = row_c_r;
        row_c_nxt  = (f_r < rows_eff) ? rd_eff : '0;
        f_nxt      = f_r + CFG_W'(1);
        wr_row_nxt = f_r[ROW_W-1:0] - ROW_W'(1);
      end
      ST_LOAD: begin
        cu_ctrl.load = 1'b1;
        col_cnt_nxt  = '0;
      end
      ST_CALC: begin
        cu_ctrl.shift = 1'b1;
        col_cnt_nxt   = col_cnt_r + COL_W'(1);
      end
      ST_WRITE: begin
        ram_we              = 1'b1;
        ram_waddr           = wr_row_r;
        ram_wdata           = (cu_row & cmask) | (row_b_r & ~cmask);
        valid_nxt[wr_row_r] = 1'b1;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = res_alive_r;
          out_kind_nxt  = res_kind_r;
          out_err_nxt   = res_err_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    rd_row_r    <= rd_row_nxt;
    col_r       <= col_nxt;
    val_r       <= val_nxt;
    f_r         <= f_nxt;
    wr_row_r    <= wr_row_nxt;
    col_cnt_r   <= col_cnt_nxt;
    row_a_r     <= row_a_nxt;
    row_b_r     <= row_b_nxt;
    row_c_r     <= row_c_nxt;
    res_alive_r <= res_alive_nxt;
    res_kind_r  <= res_kind_nxt;
    res_err_r   <= res_err_nxt;
    out_alive_r <= out_alive_nxt;
    out_kind_r  <= out_kind_nxt;
    out_err_r   <= out_err_nxt;
  end

  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_WRITE) || (state_r == ST_ACC_RD)))
    else $error("cell RAM written outside a write state");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result transaction raised without a finished command");

  a_calc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |=> ((state_r == ST_CALC) || (state_r == ST_WRITE)))
    else $error("row evaluation left early");

  a_load_clears_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (col_cnt_r == '0))
    else $error("column counter not cleared at window load");

endmodule

`default_nettype wire
